FILE: rtl/core/ele_pkg.sv
// Shared types and character codes for the echoing line editor core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package ele_pkg;

    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] MAX_LEN_RESET = 8'd64;

    typedef enum logic [1:0] {
        CMD_LINE,
        CMD_ERASE,
        CMD_STORE
    } cmd_kind_t;

    // one classified byte, as queued between front and back
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data;
        logic [7:0]  index;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef logic [1:0] beat_t;

    localparam beat_t BEAT_FIRST  = 2'd0;
    localparam beat_t BEAT_SECOND = 2'd1;
    localparam beat_t BEAT_THIRD  = 2'd2;

endpackage

FILE: rtl/core/echoing_line_editor_core.sv
// Top level of the echoing line editor: front, command queue and back.
// Depends on ele_pkg, ele_front, ele_queue and ele_back.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_ready    rx_byte
//   out       output     out_valid/out_ready  echo_byte, store_*, line_*, last
//   cfg       input      cfg_wr_en            cfg_wr_data (max_len)
//
// The front takes one byte per cycle while the queue has room; bytes that
// cause nothing are dropped there. The back emits one result per cycle while
// the output is ready: 1 (store), 2 (line end) or 3 (erase) results per byte.
// Reset clears the fill index, sets max_len to 64 and empties the queue.
// A stalled output holds the back; the front keeps going until the queue of
// QUEUE_DEPTH commands fills.
`timescale 1ns / 1ps

module echoing_line_editor_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] echo_byte,
    output logic       store_enable,
    output logic [7:0] store_index,
    output logic [7:0] store_byte,
    output logic       line_done,
    output logic [7:0] line_length,
    output logic       last
);
    import ele_pkg::*;

    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      head_cmd;
    q_status_t q_status;

    ele_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .q_status    (q_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    ele_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    ele_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_cmd     (head_cmd),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .echo_byte    (echo_byte),
        .store_enable (store_enable),
        .store_index  (store_index),
        .store_byte   (store_byte),
        .line_done    (line_done),
        .line_length  (line_length),
        .last         (last)
    );

    // a multi-result byte continues without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside a multi-result sequence");

    // line end is the LF result that also writes the terminator
    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |->
            store_enable && last && echo_byte == CH_LF && store_byte == CH_NUL
            && store_index == line_length)
        else $error("malformed line end result");

    // a character store echoes what it writes and stands alone
    a_store_echo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_enable && !line_done |-> store_byte == echo_byte && last)
        else $error("store result does not match its echo");

endmodule

FILE: rtl/core/ele_front.sv
// Front end: accepts received bytes, tracks the fill index and max_len,
// and turns each byte into a command for the queue. Depends on ele_pkg.
`timescale 1ns / 1ps

module ele_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [7:0]     cfg_wr_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     rx_byte,
    input  ele_pkg::q_status_t q_status,
    output logic           push,
    output ele_pkg::cmd_t  push_cmd
);
    import ele_pkg::*;

    logic [7:0] max_len_reg;
    logic [7:0] fill_index_reg;
    logic [7:0] fill_index_next;
    logic       accept;
    logic       is_line;
    logic       is_erase;
    logic       is_store;
    logic [8:0] fill_plus_one;

    assign in_ready      = !q_status.full;
    assign accept        = in_valid && in_ready;
    assign fill_plus_one = {1'b0, fill_index_reg} + 9'd1;

    always_comb
    begin
        is_line  = (rx_byte == CH_CR) || (rx_byte == CH_LF);
        is_erase = ((rx_byte == CH_BS) || (rx_byte == CH_DEL)) && (fill_index_reg != 8'd0);
        // DEL on an empty line falls through to the printable range
        is_store = !is_line && !is_erase && (rx_byte inside {[CH_SPACE:CH_DEL]})
                   && (fill_plus_one < {1'b0, max_len_reg});
    end

    always_comb
    begin
        push_cmd.data  = rx_byte;
        push_cmd.index = fill_index_reg;
        push_cmd.kind  = CMD_STORE;
        fill_index_next = fill_index_reg;
        if (is_line)
        begin
            push_cmd.kind   = CMD_LINE;
            fill_index_next = 8'd0;
        end
        else if (is_erase)
        begin
            push_cmd.kind   = CMD_ERASE;
            fill_index_next = fill_index_reg - 8'd1;
        end
        else if (is_store)
        begin
            fill_index_next = fill_index_reg + 8'd1;
        end
    end

    // drop bytes that cause no result
    assign push = accept && (is_line || is_erase || is_store);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= MAX_LEN_RESET;
            fill_index_reg <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                fill_index_reg <= fill_index_next;
            end
        end
    end

endmodule

FILE: rtl/core/ele_queue.sv
// Short command queue between front and back, show-ahead read.
// Depends on ele_pkg for the command type.
`timescale 1ns / 1ps

module ele_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ele_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output ele_pkg::cmd_t      head_cmd,
    output ele_pkg::q_status_t status
);
    import ele_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    cmd_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_ONE;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_ONE;
            end
        end
    end

endmodule

FILE: rtl/core/ele_back.sv
// Back end: expands the queued command into one to three echo results
// held in an output register. Depends on ele_pkg.
`timescale 1ns / 1ps

module ele_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ele_pkg::cmd_t      head_cmd,
    input  ele_pkg::q_status_t q_status,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         echo_byte,
    output logic               store_enable,
    output logic [7:0]         store_index,
    output logic [7:0]         store_byte,
    output logic               line_done,
    output logic [7:0]         line_length,
    output logic               last
);
    import ele_pkg::*;

    beat_t      beat_reg;
    logic       out_valid_reg;
    logic [7:0] echo_reg;
    logic       st_en_reg;
    logic [7:0] st_idx_reg;
    logic [7:0] st_byte_reg;
    logic       done_reg;
    logic [7:0] len_reg;
    logic       last_reg;

    logic       load;
    logic [7:0] echo_next;
    logic       st_en_next;
    logic [7:0] st_idx_next;
    logic [7:0] st_byte_next;
    logic       done_next;
    logic [7:0] len_next;
    logic       last_next;

    // refill the output register when empty or being transferred
    assign load = !q_status.empty && (!out_valid_reg || out_ready);
    assign pop  = load && last_next;

    always_comb
    begin
        echo_next    = CH_NUL;
        st_en_next   = 1'b0;
        st_idx_next  = 8'd0;
        st_byte_next = CH_NUL;
        done_next    = 1'b0;
        len_next     = 8'd0;
        last_next    = 1'b0;
        case (head_cmd.kind)
            CMD_LINE:
            begin
                if (beat_reg == BEAT_FIRST)
                begin
                    echo_next = CH_CR;
                end
                else
                begin
                    // terminator goes at the fill index
                    echo_next   = CH_LF;
                    st_en_next  = 1'b1;
                    st_idx_next = head_cmd.index;
                    done_next   = 1'b1;
                    len_next    = head_cmd.index;
                    last_next   = 1'b1;
                end
            end
            CMD_ERASE:
            begin
                echo_next = (beat_reg == BEAT_SECOND) ? CH_SPACE : CH_BS;
                last_next = (beat_reg == BEAT_THIRD);
            end
            CMD_STORE:
            begin
                echo_next    = head_cmd.data;
                st_en_next   = 1'b1;
                st_idx_next  = head_cmd.index;
                st_byte_next = head_cmd.data;
                last_next    = 1'b1;
            end
            default:
            begin
                last_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= BEAT_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                beat_reg      <= last_next ? BEAT_FIRST : beat_reg + 2'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            echo_reg    <= echo_next;
            st_en_reg   <= st_en_next;
            st_idx_reg  <= st_idx_next;
            st_byte_reg <= st_byte_next;
            done_reg    <= done_next;
            len_reg     <= len_next;
            last_reg    <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign echo_byte    = echo_reg;
    assign store_enable = st_en_reg;
    assign store_index  = st_idx_reg;
    assign store_byte   = st_byte_reg;
    assign line_done    = done_reg;
    assign line_length  = len_reg;
    assign last         = last_reg;

endmodule

FILE: verif/echoing_line_editor_core_test.sv
// Self-checking testbench for echoing_line_editor_core. Drives received bytes
// and max_len writes, predicts every echo result in-bench and checks in order.
// Depends on ele_pkg and the echoing_line_editor_core RTL.
`timescale 1ns / 1ps

module echoing_line_editor_core_test;
    import ele_pkg::*;

    localparam int  SETTLE_CYCLES = 12;
    localparam time RUN_LIMIT     = 2ms;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic       store_enable;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       line_done;
        logic [7:0] line_length;
        logic       last;
    } echo_result_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte     = 8'd0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] echo_byte;
    logic       store_enable;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       line_done;
    logic [7:0] line_length;
    logic       last;

    // in-bench copy of the editor state
    logic [7:0]   fill_level = 8'd0;
    logic [7:0]   line_limit = MAX_LEN_RESET;
    echo_result_t pending_echo[$];

    int mismatches    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len      = 0;
    int hold_count    = 0;

    echoing_line_editor_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .echo_byte    (echo_byte),
        .store_enable (store_enable),
        .store_index  (store_index),
        .store_byte   (store_byte),
        .line_done    (line_done),
        .line_length  (line_length),
        .last         (last)
    );

    always #6 clk = ~clk;

    // Queue the results one received byte causes and advance the line state.
    function automatic void predict_echo(input logic [7:0] c);
        if (c == CH_CR || c == CH_LF)
        begin
            pending_echo.push_back(echo_result_t'{CH_CR, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0});
            pending_echo.push_back(echo_result_t'{CH_LF, 1'b1, fill_level, CH_NUL,
                                                  1'b1, fill_level, 1'b1});
            fill_level = 8'd0;
        end
        else if ((c == CH_BS || c == CH_DEL) && fill_level != 8'd0)
        begin
            fill_level = fill_level - 8'd1;
            pending_echo.push_back(echo_result_t'{CH_BS, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0});
            pending_echo.push_back(echo_result_t'{CH_SPACE, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b0});
            pending_echo.push_back(echo_result_t'{CH_BS, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 1'b1});
        end
        else if (c >= CH_SPACE && c <= CH_DEL && {1'b0, fill_level} + 9'd1 < {1'b0, line_limit})
        begin
            pending_echo.push_back(echo_result_t'{c, 1'b1, fill_level, c, 1'b0, 8'd0, 1'b1});
            fill_level = fill_level + 8'd1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Predict on every input transfer, then check every output transfer.
    always @(posedge clk)
    begin : watch_ports
        echo_result_t want;
        if (in_valid && in_ready)
            predict_echo(rx_byte);
        if (out_valid && out_ready)
        begin
            if (pending_echo.size() == 0)
            begin
                $error("echo_byte: expected no result, got %0h", echo_byte);
                mismatches++;
            end
            else
            begin
                want = pending_echo.pop_front();
                check_field("echo_byte", want.echo_byte, echo_byte);
                check_field("store_enable", 8'(want.store_enable), 8'(store_enable));
                check_field("store_index", want.store_index, store_index);
                check_field("store_byte", want.store_byte, store_byte);
                check_field("line_done", 8'(want.line_done), 8'(line_done));
                check_field("line_length", want.line_length, line_length);
                check_field("last", 8'(want.last), 8'(last));
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin : drive_ready
        int hold_left;
        int hold_taken;
        if (hold_count != hold_taken)
        begin
            hold_left  = hold_len;
            hold_taken = hold_count;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one byte, with a random gap first; valid stays high after the transfer.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_echo.size() != 0)
            @(posedge clk);
        // let the bench go quiet before the next phase
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_max_len(input logic [7:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        line_limit  = value;
    endtask

    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 72)
            return 8'($urandom_range(8'h7E, 8'h20));
        if (roll < 84)
            return $urandom_range(1) ? CH_BS : CH_DEL;
        return 8'($urandom_range(255));
    endfunction

    // Lines of random text with edits; a few are left unterminated.
    task automatic send_random_lines(input int budget);
        int sent;
        int len;
        int roll;
        sent = 0;
        while (sent < budget)
        begin
            len = $urandom_range(14);
            repeat (len) send_byte(pick_byte());
            roll = $urandom_range(99);
            if (roll < 45)
                send_byte(CH_CR);
            else if (roll < 90)
                send_byte(CH_LF);
            sent += len + 1;
        end
    endtask

    task automatic test_character_classes();
        logic [7:0] seq[$];
        seq = '{8'h20, 8'h7E, 8'h41, CH_DEL, CH_BS, CH_BS, CH_BS, CH_DEL,
                8'h80, 8'hFF, 8'h00, 8'h1F, CH_CR, CH_LF, 8'h55, CH_CR};
        foreach (seq[i])
            send_byte(seq[i]);
        wait_idle();
    endtask

    task automatic test_line_limits();
        // room for two characters, the third is dropped
        set_max_len(8'd3);
        send_byte(8'h78);
        send_byte(8'h79);
        send_byte(8'h7A);
        send_byte(CH_LF);
        // no room at all: only the terminator is stored
        set_max_len(8'd0);
        send_byte(8'h61);
        send_byte(CH_LF);
        set_max_len(8'd1);
        send_byte(8'h62);
        send_byte(CH_CR);
        // shrink the limit below the current fill level
        set_max_len(8'd255);
        send_byte(8'h70);
        send_byte(8'h71);
        send_byte(8'h72);
        set_max_len(8'd2);
        send_byte(8'h73);
        send_byte(CH_BS);
        send_byte(CH_LF);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_max_len(8'd64);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len      = 80;
        hold_count++;
        repeat (5) send_byte(8'($urandom_range(8'h7E, 8'h20)));
        repeat (3) send_byte(CH_DEL);
        repeat (4) send_byte(8'($urandom_range(8'h7E, 8'h20)));
        send_byte(CH_CR);
        send_byte(CH_LF);
        // pause the sender until every result has come back
        wait_idle();
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 8;
        recv_idle_pct = 47;
        set_max_len(8'd16);
        send_random_lines(14);
        send_idle_pct = 47;
        recv_idle_pct = 8;
        set_max_len(8'd7);
        send_random_lines(14);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_max_len(8'd255);
        // one line past the largest buffer
        repeat (256) send_byte(8'($urandom_range(8'h7E, 8'h20)));
        send_byte(CH_LF);
        wait_idle();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_character_classes();
        test_line_limits();
        test_backpressure();
        test_random_traffic();
        if (mismatches == 0 && pending_echo.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
